// ----- hdl/lsh_pkg.sv -----
// Shared types, codes and reset values for the link set-up handshake block.
`timescale 1ns / 1ps
`default_nettype none

package lsh_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Link status codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_CONN = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    // Frame hunter phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_FLAG  = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_CTRL  = 3'd3;
    localparam logic [2:0] PH_BCC   = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_FLAG    = 3'd1;
    localparam logic [2:0] REG_ADDR    = 3'd2;
    localparam logic [2:0] REG_SET     = 3'd3;
    localparam logic [2:0] REG_UA      = 3'd4;
    localparam logic [2:0] REG_TRIES   = 3'd5;
    localparam logic [2:0] REG_TIMEOUT = 3'd6;

    // Frame layout: flag, address, control, check, flag
    localparam int          FRAME_LEN = 5;
    localparam logic [2:0]  IDX_FLAG0 = 3'd0;
    localparam logic [2:0]  IDX_ADDR  = 3'd1;
    localparam logic [2:0]  IDX_CTRL  = 3'd2;
    localparam logic [2:0]  IDX_BCC   = 3'd3;
    localparam logic [2:0]  IDX_FLAG1 = 3'd4;

    localparam logic [3:0]  RETRY_MAX = 4'd15;

    // Reset values of the configuration registers
    localparam logic        RST_MODE    = 1'b0;
    localparam logic [7:0]  RST_FLAG    = 8'd126;
    localparam logic [7:0]  RST_ADDR    = 8'd3;
    localparam logic [7:0]  RST_SET     = 8'd3;
    localparam logic [7:0]  RST_UA      = 8'd7;
    localparam logic [3:0]  RST_TRIES   = 4'd3;
    localparam logic [15:0] RST_TIMEOUT = 16'd3;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Configuration register set
    typedef struct packed {
        logic        mode;
        logic [7:0]  flag_byte;
        logic [7:0]  address_byte;
        logic [7:0]  set_code;
        logic [7:0]  ua_code;
        logic [3:0]  max_tries;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // Result descriptor handed from the control stage to the emitter
    typedef struct packed {
        logic       frame;   // 1: five frame bytes, 0: one empty result
        logic [7:0] ctrl;    // control byte of the frame
        logic [1:0] status;  // link status after this transaction
    } t_load;

endpackage

`default_nettype wire

// ----- hdl/lsh_hunt.sv -----
// Five-phase supervision frame recognizer: next phase for one received byte.
`timescale 1ns / 1ps
`default_nettype none

module lsh_hunt
    import lsh_pkg::*;
(
    input  wire logic [2:0] i_phase,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_ctrl,
    input  wire t_cfg       i_cfg,
    output logic      [2:0] o_phase,
    output logic            o_done
);

    logic [7:0] w_bcc;

    assign w_bcc = i_cfg.address_byte ^ i_ctrl;

    // Field match is tested ahead of the flag so overlapping values advance
    always_comb begin
        o_done  = 1'b0;
        o_phase = PH_START;
        unique case (i_phase)
            PH_START: begin
                o_phase = (i_byte == i_cfg.flag_byte) ? PH_FLAG : PH_START;
            end
            PH_FLAG: begin
                if (i_byte == i_cfg.address_byte) o_phase = PH_ADDR;
                else if (i_byte == i_cfg.flag_byte) o_phase = PH_FLAG;
            end
            PH_ADDR: begin
                if (i_byte == i_ctrl) o_phase = PH_CTRL;
                else if (i_byte == i_cfg.flag_byte) o_phase = PH_FLAG;
            end
            PH_CTRL: begin
                if (i_byte == w_bcc) o_phase = PH_BCC;
                else if (i_byte == i_cfg.flag_byte) o_phase = PH_FLAG;
            end
            PH_BCC: begin
                o_done = (i_byte == i_cfg.flag_byte);
            end
            default: begin
                o_phase = PH_START;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/lsh_ctrl.sv -----
// Link state, retry and timeout counters; decides the results of each transaction.
`timescale 1ns / 1ps
`default_nettype none

module lsh_ctrl
    import lsh_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg       i_cfg,
    output t_load           o_load
);

    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_status, n_status;
    logic [3:0]  r_retry, n_retry;
    logic [15:0] r_tick, n_tick;

    logic [7:0]  w_hunt_ctrl;
    logic [2:0]  w_hunt_phase;
    logic        w_hunt_done;
    logic [15:0] w_tick_inc;
    logic [3:0]  w_retry_inc;

    // Transmitter hunts for UA, receiver hunts for SET
    assign w_hunt_ctrl = i_cfg.mode ? i_cfg.set_code : i_cfg.ua_code;

    lsh_hunt u_hunt (
        .i_phase (r_phase),
        .i_byte  (i_byte),
        .i_ctrl  (w_hunt_ctrl),
        .i_cfg   (i_cfg),
        .o_phase (w_hunt_phase),
        .o_done  (w_hunt_done)
    );

    assign w_tick_inc  = r_tick + 16'd1;
    assign w_retry_inc = (r_retry < RETRY_MAX) ? (r_retry + 4'd1) : r_retry;

    // Next state and result descriptor
    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_retry  = r_retry;
        n_tick   = r_tick;
        o_load.frame = 1'b0;
        o_load.ctrl  = i_cfg.set_code;
        case (i_op)
            OP_START: begin
                n_phase  = PH_START;
                n_retry  = 4'd0;
                n_tick   = 16'd0;
                n_status = ST_WAIT;
                o_load.frame = ~i_cfg.mode;
            end
            OP_BYTE: begin
                if (r_status == ST_WAIT) begin
                    n_phase = w_hunt_phase;
                    if (w_hunt_done) begin
                        n_status = ST_CONN;
                        if (!i_cfg.mode) begin
                            n_tick = 16'd0;
                        end else begin
                            o_load.frame = 1'b1;
                            o_load.ctrl  = i_cfg.ua_code;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (!i_cfg.mode && r_status == ST_WAIT) begin
                    n_tick = w_tick_inc;
                    if (w_tick_inc >= i_cfg.timeout_ticks) begin
                        n_tick  = 16'd0;
                        n_retry = w_retry_inc;
                        n_phase = PH_START;
                        if (w_retry_inc >= i_cfg.max_tries) begin
                            n_status = ST_FAIL;
                        end else begin
                            o_load.frame = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        o_load.status = n_status;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_status <= ST_IDLE;
            r_retry  <= 4'd0;
            r_tick   <= 16'd0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_retry  <= n_retry;
            r_tick   <= n_tick;
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_BCC)
        else $error("hunter phase out of range");

    a_start_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_op == OP_START) |=> (r_status == ST_WAIT))
        else $error("start did not arm the handshake");

    a_fail_by_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != ST_FAIL && !(i_fire && i_op == OP_TICK)) |=> (r_status != ST_FAIL))
        else $error("link failed without a timeout");
`endif

endmodule

`default_nettype wire

// ----- hdl/lsh_emit.sv -----
// Result register and frame sequencer: one result per cycle while i_ready is high, five for a frame.
`timescale 1ns / 1ps
`default_nettype none

module lsh_emit
    import lsh_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load_valid,
    input  wire t_load      i_load,
    input  wire t_cfg       i_cfg,
    output logic            o_load_ready,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_tx_byte,
    output logic            o_tx_valid,
    output logic            o_last,
    output logic [1:0]      o_status
);

    logic       r_busy;
    logic       r_frame;
    logic [7:0] r_ctrl;
    logic [1:0] r_status;
    logic [2:0] r_idx;
    logic       w_take;
    logic [7:0] w_byte;

    assign o_last       = ~r_frame | (r_idx == IDX_FLAG1);
    assign w_take       = r_busy & i_ready;
    assign o_load_ready = ~r_busy | (i_ready & o_last);

    // Frame byte for the current position
    always_comb begin
        unique case (r_idx)
            IDX_FLAG0: w_byte = i_cfg.flag_byte;
            IDX_ADDR:  w_byte = i_cfg.address_byte;
            IDX_CTRL:  w_byte = r_ctrl;
            IDX_BCC:   w_byte = i_cfg.address_byte ^ r_ctrl;
            IDX_FLAG1: w_byte = i_cfg.flag_byte;
            default:   w_byte = 8'd0;
        endcase
    end

    assign o_valid    = r_busy;
    assign o_tx_valid = r_frame;
    assign o_tx_byte  = r_frame ? w_byte : 8'd0;
    assign o_status   = r_status;

    // Control: busy flag and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= IDX_FLAG0;
        end else if (o_load_ready) begin
            r_busy <= i_load_valid;
            r_idx  <= IDX_FLAG0;
        end else if (w_take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    // Descriptor payload
    always_ff @(posedge i_clk) begin
        if (o_load_ready && i_load_valid) begin
            r_frame  <= i_load.frame;
            r_ctrl   <= i_load.ctrl;
            r_status <= i_load.status;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_FLAG1)
        else $error("frame position out of range");

    a_single_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_frame) |-> (r_idx == IDX_FLAG0))
        else $error("empty result past first position");

    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !o_last) |=> (r_busy && r_idx == $past(r_idx) + 3'd1))
        else $error("frame cut short");
`endif

endmodule

`default_nettype wire

// ----- hdl/link_setup_handshake.sv -----
// Top level of the link set-up handshake: input register, config registers, control, emitter.
// The input register holds an accepted transaction; the result register then holds its result.
// Throughput: one transaction per cycle when each gives a single result and the output is
//   ready; a frame transaction holds the output for five frame bytes, one byte per cycle.
// The output sequencer sets the rate: one result per cycle while the output is ready.
// Reset (synchronous, active low) clears link state, counters and both stages,
//   and returns the configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module link_setup_handshake
    import lsh_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
    input  wire logic [1:0]            s_axis_tuser,  // [1:0] operation
    // Result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [15:0]                m_axis_tdata,  // [7:0] tx_byte, [9:8] status
    output logic                       m_axis_tlast,
    output logic                       m_axis_tuser,  // [0] tx_valid
    // Configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [1:0] r_op;
    logic [7:0] r_byte;
    logic       w_load_ready;
    logic       w_fire;
    t_load      w_load;
    logic [7:0] w_tx_byte;
    logic [1:0] w_status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= RST_MODE;
            r_cfg.flag_byte     <= RST_FLAG;
            r_cfg.address_byte  <= RST_ADDR;
            r_cfg.set_code      <= RST_SET;
            r_cfg.ua_code       <= RST_UA;
            r_cfg.max_tries     <= RST_TRIES;
            r_cfg.timeout_ticks <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:    r_cfg.mode          <= i_cfg_data[0];
                REG_FLAG:    r_cfg.flag_byte     <= i_cfg_data[7:0];
                REG_ADDR:    r_cfg.address_byte  <= i_cfg_data[7:0];
                REG_SET:     r_cfg.set_code      <= i_cfg_data[7:0];
                REG_UA:      r_cfg.ua_code       <= i_cfg_data[7:0];
                REG_TRIES:   r_cfg.max_tries     <= i_cfg_data[3:0];
                REG_TIMEOUT: r_cfg.timeout_ticks <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: takes a new transaction when it is empty or the current one moves on
    assign w_fire        = r_in_valid & w_load_ready;
    assign s_axis_tready = ~r_in_valid | w_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_op   <= s_axis_tuser;
            r_byte <= s_axis_tdata;
        end
    end

    lsh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_op    (r_op),
        .i_byte  (r_byte),
        .i_cfg   (r_cfg),
        .o_load  (w_load)
    );

    lsh_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid),
        .i_load       (w_load),
        .i_cfg        (r_cfg),
        .o_load_ready (w_load_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_tx_byte    (w_tx_byte),
        .o_tx_valid   (m_axis_tuser),
        .o_last       (m_axis_tlast),
        .o_status     (w_status)
    );

    assign m_axis_tdata = {6'd0, w_status, w_tx_byte};

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the link set-up handshake block.
`timescale 1ns / 1ps

module tb;
    import lsh_pkg::*;

    // Operation code outside the defined set; the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Status column filler for rows that are checked by prediction
    localparam logic [1:0] ANY_ST = ST_IDLE;

    localparam int RANDOM_ITEMS   = 185;
    localparam int SETTLE_CYCLES  = 4;     // extra wait after the last expected result
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_LIMIT    = 60;

    // One result of the block as it appears on the output stream
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       last;
        logic [1:0] status;
    } t_result;

    // Directed table: register writes, predicted rows and rows with a typed result
    typedef enum logic [1:0] {ROW_REG, ROW_ITEM, ROW_FIXED} t_row_kind;
    typedef struct {
        t_row_kind   kind;
        logic [2:0]  sel;     // register index or operation code
        logic [15:0] val;     // register value or rx byte
        logic [1:0]  st;      // status of the typed result
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;       // [7:0] rx_byte
    logic [1:0]  s_axis_tuser = 2'd0;       // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;              // [7:0] tx_byte, [9:8] status
    logic        m_axis_tlast;
    logic        m_axis_tuser;              // [0] tx_valid
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow of the block: registers and link state
    t_cfg        regs;
    logic [2:0]  hunt_ph;
    logic [1:0]  link_st;
    logic [3:0]  retries;
    logic [15:0] ticks;

    t_result     results_due[$];
    t_result     step_out[$];
    t_result     due_head;
    t_row        script[$];

    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          n_settings = 1;
    int          links_up = 0;
    int          links_failed = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          stall_pick;
    bit          steady = 1'b0;

    link_setup_handshake i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        if (errors < PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Gap length for either side: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // ---------------- prediction ----------------

    function automatic void queue_blank();
        step_out.push_back(t_result'{8'h00, 1'b0, 1'b1, link_st});
    endfunction

    // Five-byte supervision frame: flag, address, control, check, flag
    function automatic void queue_frame(input logic [7:0] ctrl);
        logic [7:0] fb [FRAME_LEN];
        fb[IDX_FLAG0] = regs.flag_byte;
        fb[IDX_ADDR]  = regs.address_byte;
        fb[IDX_CTRL]  = ctrl;
        fb[IDX_BCC]   = regs.address_byte ^ ctrl;
        fb[IDX_FLAG1] = regs.flag_byte;
        for (int k = 0; k < FRAME_LEN; k++)
            step_out.push_back(t_result'{fb[k], 1'b1, k == FRAME_LEN - 1, link_st});
    endfunction

    // Frame hunter; address, control and check matches win over a flag match
    function automatic bit hunt_byte(input logic [7:0] b, input logic [7:0] ctrl);
        bit done;
        done = 1'b0;
        case (hunt_ph)
            PH_START: begin
                if (b == regs.flag_byte) hunt_ph = PH_FLAG;
            end
            PH_FLAG: begin
                if (b == regs.address_byte)   hunt_ph = PH_ADDR;
                else if (b == regs.flag_byte) hunt_ph = PH_FLAG;
                else                          hunt_ph = PH_START;
            end
            PH_ADDR: begin
                if (b == ctrl)                hunt_ph = PH_CTRL;
                else if (b == regs.flag_byte) hunt_ph = PH_FLAG;
                else                          hunt_ph = PH_START;
            end
            PH_CTRL: begin
                if (b == (regs.address_byte ^ ctrl)) hunt_ph = PH_BCC;
                else if (b == regs.flag_byte)        hunt_ph = PH_FLAG;
                else                                 hunt_ph = PH_START;
            end
            PH_BCC: begin
                done = (b == regs.flag_byte);
                hunt_ph = PH_START;
            end
            default: hunt_ph = PH_START;
        endcase
        return done;
    endfunction

    // Results of one input transaction, appended to step_out
    function automatic void advance_link(input logic [1:0] op, input logic [7:0] b);
        case (op)
            OP_START: begin
                hunt_ph = PH_START;
                retries = 4'd0;
                ticks   = 16'd0;
                link_st = ST_WAIT;
                if (!regs.mode) queue_frame(regs.set_code);
                else            queue_blank();
            end
            OP_BYTE: begin
                if (link_st != ST_WAIT) begin
                    queue_blank();
                end else if (!regs.mode) begin
                    if (hunt_byte(b, regs.ua_code)) begin
                        link_st = ST_CONN;
                        ticks   = 16'd0;
                        links_up++;
                    end
                    queue_blank();
                end else if (hunt_byte(b, regs.set_code)) begin
                    link_st = ST_CONN;
                    links_up++;
                    queue_frame(regs.ua_code);
                end else begin
                    queue_blank();
                end
            end
            OP_TICK: begin
                if (!regs.mode && link_st == ST_WAIT) begin
                    ticks = ticks + 16'd1;
                    if (ticks >= regs.timeout_ticks) begin
                        ticks = 16'd0;
                        if (retries != RETRY_MAX) retries = retries + 4'd1;
                        hunt_ph = PH_START;
                        if (retries >= regs.max_tries) begin
                            link_st = ST_FAIL;
                            links_failed++;
                            queue_blank();
                        end else begin
                            queue_frame(regs.set_code);
                        end
                    end else begin
                        queue_blank();
                    end
                end else begin
                    queue_blank();
                end
            end
            default: queue_blank();
        endcase
    endfunction

    // ---------------- drivers ----------------

    // One input transaction; returns at the edge where it is accepted
    task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                             input bit typed, input logic [1:0] st);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        step_out.delete();
        advance_link(op, data);
        if (typed)
            results_due.push_back(t_result'{8'h00, 1'b0, 1'b1, st});
        else
            foreach (step_out[k]) results_due.push_back(step_out[k]);
    endtask

    // Stop sending and wait for every expected result, plus the pipeline depth
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; the caller lowers the write enable after a group
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_MODE:    regs.mode          = val[0];
            REG_FLAG:    regs.flag_byte     = val[7:0];
            REG_ADDR:    regs.address_byte  = val[7:0];
            REG_SET:     regs.set_code      = val[7:0];
            REG_UA:      regs.ua_code       = val[7:0];
            REG_TRIES:   regs.max_tries     = val[3:0];
            REG_TIMEOUT: regs.timeout_ticks = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(REG_MODE,    {15'd0, c.mode});
        write_reg(REG_FLAG,    {8'd0, c.flag_byte});
        write_reg(REG_ADDR,    {8'd0, c.address_byte});
        write_reg(REG_SET,     {8'd0, c.set_code});
        write_reg(REG_UA,      {8'd0, c.ua_code});
        write_reg(REG_TRIES,   {12'd0, c.max_tries});
        write_reg(REG_TIMEOUT, c.timeout_ticks);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Random register set, with field overlaps and timing extremes now and then
    function automatic t_cfg pick_settings();
        t_cfg c;
        int r;
        c.mode = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) c.flag_byte = RST_FLAG;
        else                           c.flag_byte = 8'($urandom_range(0, 255));
        c.address_byte = 8'($urandom_range(0, 255));
        c.set_code     = 8'($urandom_range(0, 255));
        c.ua_code      = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r == 0)      c.address_byte = c.flag_byte;
        else if (r == 1) c.set_code     = c.flag_byte;
        else if (r == 2) c.ua_code      = c.flag_byte;
        if ($urandom_range(0, 4) == 0) c.max_tries = RETRY_MAX;
        else                           c.max_tries = 4'($urandom_range(1, 4));
        r = $urandom_range(0, 9);
        if (r == 0)      c.timeout_ticks = 16'hFFFF;
        else if (r == 1) c.timeout_ticks = 16'd1;
        else             c.timeout_ticks = 16'($urandom_range(1, 6));
        return c;
    endfunction

    // Frame bytes as transactions, optionally with one byte spoiled
    task automatic send_frame(input logic [7:0] ctrl, input bit spoil);
        logic [7:0] fb [FRAME_LEN];
        fb[IDX_FLAG0] = regs.flag_byte;
        fb[IDX_ADDR]  = regs.address_byte;
        fb[IDX_CTRL]  = ctrl;
        fb[IDX_BCC]   = regs.address_byte ^ ctrl;
        fb[IDX_FLAG1] = regs.flag_byte;
        if (spoil)
            fb[$urandom_range(0, FRAME_LEN - 1)] = 8'($urandom_range(0, 255));
        for (int k = 0; k < FRAME_LEN; k++)
            send_item(OP_BYTE, fb[k], 1'b0, ANY_ST);
    endtask

    // Random traffic under one register setting: frames of the awaited kind most often
    task automatic run_phase(input int n);
        int r;
        int stop_at;
        logic [7:0] awaited;
        logic [7:0] other;
        stop_at = items_sent + n;
        awaited = regs.mode ? regs.set_code : regs.ua_code;
        other   = regs.mode ? regs.ua_code : regs.set_code;
        send_item(OP_START, 8'($urandom_range(0, 255)), 1'b0, ANY_ST);
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                send_item(OP_START, 8'($urandom_range(0, 255)), 1'b0, ANY_ST);
            else if (r < 50)
                send_frame(awaited, $urandom_range(0, 3) == 0);
            else if (r < 72)
                send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, ANY_ST);
            else if (r < 86)
                send_item(OP_BYTE, $urandom_range(0, 1) ? regs.flag_byte
                                                        : 8'($urandom_range(0, 255)),
                          1'b0, ANY_ST);
            else if (r < 92)
                send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'b0, ANY_ST);
            else if (r < 97)
                send_frame(other, 1'b0);
            else
                settle();
        end
    endtask

    function automatic void add_row(input t_row_kind kind, input logic [2:0] sel,
                                    input logic [15:0] val, input logic [1:0] st);
        script.push_back(t_row'{kind, sel, val, st});
    endfunction

    // Table row that carries an input transaction
    function automatic void add_item(input t_row_kind kind, input logic [1:0] op,
                                     input logic [15:0] val, input logic [1:0] st);
        add_row(kind, {1'b0, op}, val, st);
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing expected (%04h)",
                                     results_seen, m_axis_tdata));
            end else begin
                due_head = results_due.pop_front();
                if (m_axis_tdata[7:0] !== due_head.tx_byte)
                    flag_error($sformatf("result %0d: tx_byte %02h, expected %02h",
                                         results_seen, m_axis_tdata[7:0], due_head.tx_byte));
                if (m_axis_tuser !== due_head.tx_valid)
                    flag_error($sformatf("result %0d: tx_valid %b, expected %b",
                                         results_seen, m_axis_tuser, due_head.tx_valid));
                if (m_axis_tlast !== due_head.last)
                    flag_error($sformatf("result %0d: last %b, expected %b",
                                         results_seen, m_axis_tlast, due_head.last));
                if (m_axis_tdata[9:8] !== due_head.status)
                    flag_error($sformatf("result %0d: status %0d, expected %0d",
                                         results_seen, m_axis_tdata[9:8], due_head.status));
            end
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            stall_pick = pick_gap();
            if (stall_pick == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_pick - 1;
            end
        end
    end

    // Watchdog: too long without any transaction on either stream
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("** link_setup_handshake: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        int directed_items;
        bit cfg_open;

        regs    = t_cfg'{RST_MODE, RST_FLAG, RST_ADDR, RST_SET, RST_UA, RST_TRIES, RST_TIMEOUT};
        hunt_ph = PH_START;
        link_st = ST_IDLE;
        retries = 4'd0;
        ticks   = 16'd0;
        cfg_open = 1'b0;

        // Reset defaults, transmitter: ignored items while idle, then SET out and UA in
        add_item(ROW_FIXED, OP_BYTE,   16'h7E, ST_IDLE);
        add_item(ROW_FIXED, OP_TICK,   16'h00, ST_IDLE);
        add_item(ROW_FIXED, OP_UNUSED, 16'hFF, ST_IDLE);
        add_item(ROW_ITEM,  OP_START,  16'h00, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'h7E, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'h03, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'h07, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'h04, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'h7E, ANY_ST);
        // Zero timeout and zero try limit: the first tick fails the link
        add_row(ROW_REG,   REG_TIMEOUT, 16'd0, ANY_ST);
        add_row(ROW_REG,   REG_TRIES,   16'd0, ANY_ST);
        add_item(ROW_ITEM,  OP_START,  16'h00, ANY_ST);
        add_item(ROW_FIXED, OP_TICK,   16'h00, ST_FAIL);
        // Receiver with address and UA control equal to the flag
        add_row(ROW_REG,   REG_MODE,  16'd1,   ANY_ST);
        add_row(ROW_REG,   REG_FLAG,  16'hFF,  ANY_ST);
        add_row(ROW_REG,   REG_ADDR,  16'hFF,  ANY_ST);
        add_row(ROW_REG,   REG_SET,   16'h00,  ANY_ST);
        add_row(ROW_REG,   REG_UA,    16'hFF,  ANY_ST);
        add_item(ROW_FIXED, OP_START,  16'h00, ST_WAIT);
        add_item(ROW_FIXED, OP_TICK,   16'h00, ST_WAIT);
        add_item(ROW_ITEM,  OP_BYTE,   16'hFF, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'hFF, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'h00, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'hFF, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'hFF, ANY_ST);
        // Transmitter, largest try limit and timeout, UA control equal to the flag
        add_row(ROW_REG,   REG_MODE,    16'd0,    ANY_ST);
        add_row(ROW_REG,   REG_FLAG,    16'h00,   ANY_ST);
        add_row(ROW_REG,   REG_ADDR,    16'h80,   ANY_ST);
        add_row(ROW_REG,   REG_SET,     16'h01,   ANY_ST);
        add_row(ROW_REG,   REG_UA,      16'h00,   ANY_ST);
        add_row(ROW_REG,   REG_TRIES,   16'd15,   ANY_ST);
        add_row(ROW_REG,   REG_TIMEOUT, 16'hFFFF, ANY_ST);
        add_item(ROW_ITEM,  OP_START,  16'h00, ANY_ST);
        add_item(ROW_FIXED, OP_TICK,   16'h00, ST_WAIT);
        add_item(ROW_ITEM,  OP_BYTE,   16'h00, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'h80, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'h00, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'h80, ANY_ST);
        add_item(ROW_ITEM,  OP_BYTE,   16'h00, ANY_ST);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                if (!cfg_open) begin
                    settle();
                    n_settings++;
                end
                cfg_open = 1'b1;
                write_reg(script[i].sel, script[i].val);
            end else begin
                if (cfg_open) i_cfg_we <= 1'b0;
                cfg_open = 1'b0;
                send_item(script[i].sel[1:0], script[i].val[7:0],
                          script[i].kind == ROW_FIXED, script[i].st);
            end
        end
        directed_items = items_sent;

        // Random phases, each under a fresh register setting
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            settle();
            steady = ($urandom_range(0, 3) == 0);
            load_settings(pick_settings());
            run_phase($urandom_range(15, 35));
        end
        steady = 1'b0;
        settle();

        if (results_due.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", results_due.size()));

        $display("Covered %0d input transactions (%0d directed) under %0d register settings.",
                 items_sent, directed_items, n_settings);
        $display("Checked %0d results; %0d links came up and %0d set-ups failed on retries.",
                 results_seen, links_up, links_failed);
        if (errors == 0) begin
            $display("** link_setup_handshake: PASSED **");
        end else begin
            $display("** link_setup_handshake: FAILED **");
        end
        $finish;
    end

endmodule

// ----- link_setup_handshake.f -----
hdl/lsh_pkg.sv
hdl/lsh_hunt.sv
hdl/lsh_ctrl.sv
hdl/lsh_emit.sv
hdl/link_setup_handshake.sv
sim/tb.sv
